[design/trm_pkg.sv]
// Package with the shared codes, constants and control structs of the register machine.
package trm_pkg;

   // Default location width.
   localparam int VALUE_WIDTH_DEF = 32;

   // Instruction codes.
   localparam logic [3:0] OP_READ  = 4'd0;
   localparam logic [3:0] OP_WRITE = 4'd1;
   localparam logic [3:0] OP_MOVE  = 4'd2;
   localparam logic [3:0] OP_ADD   = 4'd3;
   localparam logic [3:0] OP_SUB   = 4'd4;
   localparam logic [3:0] OP_MULT  = 4'd5;
   localparam logic [3:0] OP_DIV   = 4'd6;
   localparam logic [3:0] OP_MOD   = 4'd7;
   localparam logic [3:0] OP_COMP  = 4'd8;

   // Location map.
   localparam int         NUM_LOCS    = 15;
   localparam logic [3:0] LOC_R0      = 4'd0;
   localparam logic [3:0] LAST_REG    = 4'd3;
   localparam logic [3:0] LOC_ZF      = 4'd12;
   localparam logic [3:0] LOC_SF      = 4'd13;
   localparam logic [3:0] LOC_OF      = 4'd14;
   localparam logic [3:0] LOC_INVALID = 4'd15;

   // Reset value of registers and memory words.
   localparam int RESET_VALUE = 128;

   // Values in -128..127 have all bits from this one up equal.
   localparam int RANGE_LSB = 7;

   // Response status codes.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_LOC  = 2'd1;
   localparam logic [1:0] STAT_DIV_ZERO = 2'd2;

   // Request from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic       start;
      logic [3:0] op;
   } alu_ctrl_type;

   // Status from the arithmetic unit back to the sequencer.
   typedef struct packed {
      logic done;
      logic div_zero;
      logic less;
      logic equal;
   } alu_stat_type;

   // Write port command of the location store.
   typedef struct packed {
      logic       en;
      logic [3:0] addr;
   } store_wr_type;

endpackage

[design/toy_register_machine_execute.sv]
// Top level of the register machine: instruction sequencer, location store and arithmetic unit.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | op, first_loc, second_loc, immediate
//   rsp     | out       | rsp_valid / rsp_stall | value, status
//
// One instruction is in flight at a time; the shared adder in the arithmetic unit handles one
// multiplier or quotient bit per cycle.
// Reset is synchronous and active high; it returns every location to its initial value.
// A stalled response holds the sequencer in its last step; a new request may be taken
// while the previous response still waits.
module toy_register_machine_execute #(
   parameter int VALUE_WIDTH = trm_pkg::VALUE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_op,
   input  logic [3:0]         req_first_loc,
   input  logic [3:0]         req_second_loc,
   input  logic signed [31:0] req_immediate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);

   localparam int W = VALUE_WIDTH;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_WR2    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [3:0]          op_ff, op_in;
   logic [3:0]          a_ff, a_in;
   logic [3:0]          b_ff, b_in;
   logic signed [31:0]  imm_ff, imm_in;
   logic [W-1:0]        value_ff, value_in;
   logic [1:0]          status_ff, status_in;
   logic [3:0]          wr2_addr_ff, wr2_addr_in;
   logic [W-1:0]        wr2_data_ff, wr2_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                req_accept;
   logic [3:0]          rd_addr_a;
   logic [3:0]          rd_addr_b;
   logic [W-1:0]        rd_data_a;
   logic [W-1:0]        rd_data_b;
   trm_pkg::store_wr_type wr;
   logic [W-1:0]        wr_data;
   trm_pkg::alu_ctrl_type alu_ctrl;
   trm_pkg::alu_stat_type alu_stat;
   logic [W-1:0]        alu_result;
   logic [63:0]         imm_ext;
   logic [W-1:0]        imm_w;
   logic [63:0]         value_ext;
   logic                pair_bad;

   // True when a value lies outside -128..127.
   function automatic logic out_of_range(input logic [W-1:0] v);
      return !((&v[W-1:trm_pkg::RANGE_LSB]) || !(|v[W-1:trm_pkg::RANGE_LSB]));
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Immediate wrapped to the location width; result sign-extended to the port width.
   assign imm_ext   = 64'(imm_ff);
   assign imm_w     = imm_ext[W-1:0];
   assign value_ext = 64'($signed(value_ff));

   // Neither operand a register, or an operand with no location.
   assign pair_bad = (a_ff > trm_pkg::LAST_REG && b_ff > trm_pkg::LAST_REG)
                     || a_ff == trm_pkg::LOC_INVALID || b_ff == trm_pkg::LOC_INVALID;

   // Reads are issued from the request itself while idle so the data is ready next cycle.
   assign rd_addr_a = (state_ff == ST_IDLE) ? req_first_loc : a_ff;
   assign rd_addr_b = (state_ff == ST_IDLE) ? req_second_loc : b_ff;

   trm_store #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr        (wr),
      .wr_data   (wr_data)
   );

   trm_alu #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opnd_x (rd_data_a),
      .opnd_y (rd_data_b),
      .stat   (alu_stat),
      .result (alu_result)
   );

   // Instruction sequencer.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      imm_in        = imm_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      wr2_addr_in   = wr2_addr_ff;
      wr2_data_in   = wr2_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr.en         = 1'b0;
      wr.addr       = trm_pkg::LOC_R0;
      wr_data       = '0;
      alu_ctrl.start = 1'b0;
      alu_ctrl.op    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_op;
               a_in      = req_first_loc;
               b_in      = req_second_loc;
               imm_in    = req_immediate;
               value_in  = '0;
               status_in = trm_pkg::STAT_OK;
               state_in  = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_FINISH;
            case (op_ff)
               trm_pkg::OP_READ: begin
                  // The overflow flag is written first, so a read into it wins.
                  wr.en   = 1'b1;
                  wr.addr = trm_pkg::LOC_OF;
                  wr_data = W'(out_of_range(imm_w));
                  if (a_ff != trm_pkg::LOC_INVALID) begin
                     wr2_addr_in = a_ff;
                     wr2_data_in = imm_w;
                     state_in    = ST_WR2;
                  end else begin
                     status_in = trm_pkg::STAT_BAD_LOC;
                  end
               end
               trm_pkg::OP_WRITE: begin
                  if (a_ff != trm_pkg::LOC_INVALID) begin
                     value_in = rd_data_a;
                  end else begin
                     status_in = trm_pkg::STAT_BAD_LOC;
                  end
               end
               trm_pkg::OP_MOVE, trm_pkg::OP_ADD, trm_pkg::OP_SUB, trm_pkg::OP_MULT,
               trm_pkg::OP_DIV, trm_pkg::OP_MOD, trm_pkg::OP_COMP: begin
                  if (pair_bad) begin
                     status_in = trm_pkg::STAT_BAD_LOC;
                  end else if (op_ff == trm_pkg::OP_MOVE) begin
                     wr.en   = 1'b1;
                     wr.addr = b_ff;
                     wr_data = rd_data_a;
                  end else begin
                     alu_ctrl.start = 1'b1;
                     state_in       = ST_EXEC;
                  end
               end
               default: begin
                  status_in = trm_pkg::STAT_OK;
               end
            endcase
         end
         ST_EXEC: begin
            if (alu_stat.done) begin
               if (alu_stat.div_zero) begin
                  status_in = trm_pkg::STAT_DIV_ZERO;
                  state_in  = ST_FINISH;
               end else if (op_ff == trm_pkg::OP_COMP) begin
                  wr.en       = 1'b1;
                  wr.addr     = trm_pkg::LOC_ZF;
                  wr_data     = W'(alu_stat.equal);
                  wr2_addr_in = trm_pkg::LOC_SF;
                  wr2_data_in = W'(alu_stat.less);
                  state_in    = ST_WR2;
               end else begin
                  wr.en       = 1'b1;
                  wr.addr     = trm_pkg::LOC_R0;
                  wr_data     = alu_result;
                  value_in    = alu_result;
                  wr2_addr_in = trm_pkg::LOC_OF;
                  wr2_data_in = W'(out_of_range(alu_result));
                  state_in    = ST_WR2;
               end
            end
         end
         ST_WR2: begin
            wr.en    = 1'b1;
            wr.addr  = wr2_addr_ff;
            wr_data  = wr2_data_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Load the response register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_ext[31:0];
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      imm_ff        <= imm_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      wr2_addr_ff   <= wr2_addr_in;
      wr2_data_ff   <= wr2_data_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // A new response appears only out of the final step of an instruction.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the final step");

   // The arithmetic unit reports completion only while the sequencer waits for it.
   a_alu_done_in_exec: assert property (@(posedge clock) disable iff (reset)
      alu_stat.done |-> state_ff == ST_EXEC)
      else $error("arithmetic unit finished while not awaited");

   // Only one instruction is in flight: an accepted request blocks the next one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("second request taken while an instruction is in flight");

   // Divide by zero is only reported after the arithmetic unit ran.
   a_div_zero_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status_ff == trm_pkg::STAT_DIV_ZERO)
      |-> (op_ff == trm_pkg::OP_DIV || op_ff == trm_pkg::OP_MOD))
      else $error("divide by zero status on an instruction that does not divide");

endmodule

[design/trm_store.sv]
// Location store: fifteen words with two registered read ports and one write port.
module trm_store #(
   parameter int VALUE_WIDTH = trm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [3:0]               rd_addr_a,
   input  logic [3:0]               rd_addr_b,
   output logic [VALUE_WIDTH-1:0]   rd_data_a,
   output logic [VALUE_WIDTH-1:0]   rd_data_b,
   input  trm_pkg::store_wr_type    wr,
   input  logic [VALUE_WIDTH-1:0]   wr_data
);

   logic [VALUE_WIDTH-1:0]        mem [trm_pkg::NUM_LOCS];
   logic [trm_pkg::NUM_LOCS-1:0]  valid_ff;
   logic [VALUE_WIDTH-1:0]        rd_a_ff;
   logic [VALUE_WIDTH-1:0]        rd_b_ff;

   // Value of a location that has not been written since reset.
   function automatic logic [VALUE_WIDTH-1:0] reset_value(input logic [3:0] addr);
      return (addr < trm_pkg::LOC_ZF) ? VALUE_WIDTH'(trm_pkg::RESET_VALUE) : '0;
   endfunction

   // A location becomes valid at its first write.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && wr.addr != trm_pkg::LOC_INVALID) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Storage array.
   always_ff @(posedge clock) begin
      if (wr.en && wr.addr != trm_pkg::LOC_INVALID) begin
         mem[wr.addr] <= wr_data;
      end
   end

   // Registered reads; unwritten locations read as their reset value.
   always_ff @(posedge clock) begin
      if (rd_addr_a != trm_pkg::LOC_INVALID && valid_ff[rd_addr_a]) begin
         rd_a_ff <= mem[rd_addr_a];
      end else begin
         rd_a_ff <= reset_value(rd_addr_a);
      end
      if (rd_addr_b != trm_pkg::LOC_INVALID && valid_ff[rd_addr_b]) begin
         rd_b_ff <= mem[rd_addr_b];
      end else begin
         rd_b_ff <= reset_value(rd_addr_b);
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[design/trm_alu.sv]
// Iterative arithmetic unit built around one shared adder: add, subtract, compare,
// shift-add multiply and restoring divide.
module trm_alu #(
   parameter int VALUE_WIDTH = trm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  trm_pkg::alu_ctrl_type    ctrl,
   input  logic [VALUE_WIDTH-1:0]   opnd_x,
   input  logic [VALUE_WIDTH-1:0]   opnd_y,
   output trm_pkg::alu_stat_type    stat,
   output logic [VALUE_WIDTH-1:0]   result
);

   localparam int W     = VALUE_WIDTH;
   localparam int CNT_W = $clog2(W);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ONE  = 3'd1;
   localparam logic [2:0] S_NEGX = 3'd2;
   localparam logic [2:0] S_NEGY = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_FIX  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       op_ff, op_in;
   logic [W-1:0]     xa_ff, xa_in;
   logic [W-1:0]     yb_ff, yb_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic             nx_ff, nx_in;
   logic             ny_ff, ny_in;
   logic             dz_ff, dz_in;
   logic             lt_ff, lt_in;
   logic             eq_ff, eq_in;

   logic [W:0]       add_a;
   logic [W:0]       add_b;
   logic             add_cin;
   logic [W:0]       sum;
   logic [W:0]       div_shift;
   logic             fix_neg;
   logic [W-1:0]     fix_src;

   // Partial remainder shifted left by one with the next dividend bit.
   assign div_shift = {acc_ff, yb_ff[W-1]};

   // Sign correction after the divide: quotient or remainder.
   assign fix_neg = (op_ff == trm_pkg::OP_DIV) ? (nx_ff ^ ny_ff) : ny_ff;
   assign fix_src = (op_ff == trm_pkg::OP_DIV) ? yb_ff : acc_ff;

   // Operand selection for the shared adder.
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      case (state_ff)
         S_ONE: begin
            add_a = {yb_ff[W-1], yb_ff};
            if (op_ff == trm_pkg::OP_ADD) begin
               add_b = {xa_ff[W-1], xa_ff};
            end else begin
               add_b   = ~{xa_ff[W-1], xa_ff};
               add_cin = 1'b1;
            end
         end
         S_NEGX: begin
            add_b   = ~{1'b0, xa_ff};
            add_cin = 1'b1;
         end
         S_NEGY: begin
            add_b   = ~{1'b0, yb_ff};
            add_cin = 1'b1;
         end
         S_MUL: begin
            add_a = {1'b0, acc_ff};
            add_b = xa_ff[0] ? {1'b0, yb_ff} : '0;
         end
         S_DIV: begin
            add_a   = div_shift;
            add_b   = ~{1'b0, xa_ff};
            add_cin = 1'b1;
         end
         S_FIX: begin
            add_b   = ~{1'b0, fix_src};
            add_cin = 1'b1;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   assign sum = add_a + add_b + (W+1)'(add_cin);

   // Sequencer of the unit.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      xa_in    = xa_ff;
      yb_in    = yb_ff;
      acc_in   = acc_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      dz_in    = dz_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               op_in  = ctrl.op;
               xa_in  = opnd_x;
               yb_in  = opnd_y;
               nx_in  = opnd_x[W-1];
               ny_in  = opnd_y[W-1];
               acc_in = '0;
               dz_in  = 1'b0;
               cnt_in = CNT_W'(W - 1);
               if (ctrl.op inside {trm_pkg::OP_ADD, trm_pkg::OP_SUB, trm_pkg::OP_COMP}) begin
                  state_in = S_ONE;
               end else if (ctrl.op == trm_pkg::OP_MULT) begin
                  state_in = S_MUL;
               end else if (ctrl.op inside {trm_pkg::OP_DIV, trm_pkg::OP_MOD}) begin
                  if (opnd_x == '0) begin
                     dz_in    = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_NEGX;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ONE: begin
            acc_in   = sum[W-1:0];
            lt_in    = sum[W];
            eq_in    = (sum == '0);
            state_in = S_DONE;
         end
         S_NEGX: begin
            if (nx_ff) begin
               xa_in = sum[W-1:0];
            end
            state_in = S_NEGY;
         end
         S_NEGY: begin
            if (ny_ff) begin
               yb_in = sum[W-1:0];
            end
            state_in = S_DIV;
         end
         S_MUL: begin
            // One multiplier bit per cycle, product kept to the location width.
            acc_in = sum[W-1:0];
            xa_in  = xa_ff >> 1;
            yb_in  = yb_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            // One quotient bit per cycle; keep the trial difference when it is not negative.
            if (!sum[W]) begin
               acc_in = sum[W-1:0];
               yb_in  = {yb_ff[W-2:0], 1'b1};
            end else begin
               acc_in = div_shift[W-1:0];
               yb_in  = {yb_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            acc_in   = fix_neg ? sum[W-1:0] : fix_src;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      xa_ff  <= xa_in;
      yb_ff  <= yb_in;
      acc_ff <= acc_in;
      nx_ff  <= nx_in;
      ny_ff  <= ny_in;
      dz_ff  <= dz_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign stat.done     = (state_ff == S_DONE);
   assign stat.div_zero = dz_ff;
   assign stat.less     = lt_ff;
   assign stat.equal    = eq_ff;
   assign result        = acc_ff;

endmodule
